### hw/rtl/hsvc_pkg.sv
// Shared types, constants and helpers for the HSV to RGB converter.
package hsvc_pkg;

  localparam int NUM_STAGES = 6;

  localparam logic [10:0] HUE_OFFSET  = 11'd720;
  localparam logic [10:0] CIRCLE_1    = 11'd360;
  localparam logic [10:0] CIRCLE_2    = 11'd720;
  localparam logic [10:0] CIRCLE_3    = 11'd1080;
  localparam logic [7:0]  CHANNEL_MAX = 8'd255;

  // register indexes (paddr[2])
  localparam logic REG_SATURATION = 1'b0;
  localparam logic REG_VALUE      = 1'b1;

  localparam logic [7:0] SATURATION_RESET = 8'd255;
  localparam logic [7:0] VALUE_RESET      = 8'd220;

  // 60-degree sectors
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;
  localparam logic [2:0] SEC_MR = 3'd5;

  typedef struct packed {
    logic [7:0] saturation;
    logic [7:0] value_level;
  } config_t;

  // floor(x / 255), exact for x up to 255 * 255
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = 17'(x) + 17'(x[15:8]) + 17'd1;
    return sum[15:8];
  endfunction

endpackage

### hw/rtl/hsvc_regs.sv
// APB configuration registers: saturation and value level.
module hsvc_regs (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output hsvc_pkg::config_t     cfg
);
  import hsvc_pkg::*;

  logic [7:0] saturation;
  logic [7:0] value_level;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      saturation  <= SATURATION_RESET;
      value_level <= VALUE_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_SATURATION: saturation  <= pwdata[7:0];
        REG_VALUE:      value_level <= pwdata[7:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SATURATION: prdata = {24'd0, saturation};
      REG_VALUE:      prdata = {24'd0, value_level};
      default:        prdata = 32'd0;
    endcase
  end

  assign cfg.saturation  = saturation;
  assign cfg.value_level = value_level;

endmodule

### hw/rtl/hsvc_flow.sv
// Pipeline valid bits and per-stage load enables with stall backpressure.
module hsvc_flow (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [hsvc_pkg::NUM_STAGES-1:0] load
);
  import hsvc_pkg::*;

  logic [NUM_STAGES-1:0] valid;
  logic [NUM_STAGES:0]   ready;

  // a stage loads when it is empty or the one after it moves
  always_comb begin
    ready[NUM_STAGES] = !out_stall;
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      ready[i] = !valid[i] || ready[i+1];
    end
  end

  assign load = ready[NUM_STAGES-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (ready[0]) valid[0] <= in_valid;
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ready[i]) valid[i] <= valid[i-1];
      end
    end
  end

  assign in_stall  = !ready[0];
  assign out_valid = valid[NUM_STAGES-1];

endmodule

### hw/rtl/hsvc_sector.sv
// Stages 1-2: hue wrap into 0..359, sector split and fractional remainder.
module hsvc_sector (
  input  logic                            clk,
  input  logic [hsvc_pkg::NUM_STAGES-1:0] load,
  input  logic signed [9:0]               hue,
  output logic [2:0]                      sector,
  output logic [7:0]                      frac
);
  import hsvc_pkg::*;

  logic [10:0] shifted;
  logic [8:0]  h_next;
  logic [8:0]  h;
  logic [2:0]  sector_next;
  logic [8:0]  base;
  logic [5:0]  rem;
  logic [9:0]  rem17;

  // hue + 720 lies in 208..1231
  assign shifted = {hue[9], hue} + HUE_OFFSET;

  always_comb begin
    priority if (shifted >= CIRCLE_3) h_next = 9'(shifted - CIRCLE_3);
    else if (shifted >= CIRCLE_2)     h_next = 9'(shifted - CIRCLE_2);
    else if (shifted >= CIRCLE_1)     h_next = 9'(shifted - CIRCLE_1);
    else                              h_next = shifted[8:0];
  end

  always_ff @(posedge clk) begin
    if (load[0]) h <= h_next;
  end

  always_comb begin
    priority if (h >= 9'd300) begin sector_next = SEC_MR; base = 9'd300; end
    else if (h >= 9'd240)     begin sector_next = SEC_BM; base = 9'd240; end
    else if (h >= 9'd180)     begin sector_next = SEC_CB; base = 9'd180; end
    else if (h >= 9'd120)     begin sector_next = SEC_GC; base = 9'd120; end
    else if (h >= 9'd60)      begin sector_next = SEC_YG; base = 9'd60;  end
    else                      begin sector_next = SEC_RY; base = 9'd0;   end
  end

  assign rem = 6'(h - base);
  // rem * 255 / 60 == rem * 17 / 4
  assign rem17 = {rem, 4'd0} + 10'(rem);

  always_ff @(posedge clk) begin
    if (load[1]) begin
      sector <= sector_next;
      frac   <= rem17[9:2];
    end
  end

endmodule

### hw/rtl/hsvc_shade.sv
// Stages 3-6: p, q, t products, divisions by 255 and channel mapping.
module hsvc_shade (
  input  logic                            clk,
  input  logic [hsvc_pkg::NUM_STAGES-1:0] load,
  input  hsvc_pkg::config_t               cfg,
  input  logic [2:0]                      sector,
  input  logic [7:0]                      frac,
  output logic [7:0]                      red,
  output logic [7:0]                      green,
  output logic [7:0]                      blue
);
  import hsvc_pkg::*;

  logic [15:0] prod_sf, prod_sr, prod_vp;
  logic [2:0]  sector3, sector4, sector5;
  logic [7:0]  q_term, t_term, p4, p5;
  logic [15:0] prod_vq, prod_vt;
  logic [7:0]  q, t, v;

  assign v = cfg.value_level;

  // stage 3
  always_ff @(posedge clk) begin
    if (load[2]) begin
      prod_sf <= cfg.saturation * frac;
      prod_sr <= cfg.saturation * (CHANNEL_MAX - frac);
      prod_vp <= v * (CHANNEL_MAX - cfg.saturation);
      sector3 <= sector;
    end
  end

  // stage 4
  always_ff @(posedge clk) begin
    if (load[3]) begin
      q_term  <= CHANNEL_MAX - div255(prod_sf);
      t_term  <= CHANNEL_MAX - div255(prod_sr);
      p4      <= div255(prod_vp);
      sector4 <= sector3;
    end
  end

  // stage 5
  always_ff @(posedge clk) begin
    if (load[4]) begin
      prod_vq <= v * q_term;
      prod_vt <= v * t_term;
      p5      <= p4;
      sector5 <= sector4;
    end
  end

  // stage 6
  assign q = div255(prod_vq);
  assign t = div255(prod_vt);

  always_ff @(posedge clk) begin
    if (load[5]) begin
      unique case (sector5)
        SEC_RY:  begin red <= v;  green <= t;  blue <= p5; end
        SEC_YG:  begin red <= q;  green <= v;  blue <= p5; end
        SEC_GC:  begin red <= p5; green <= v;  blue <= t;  end
        SEC_CB:  begin red <= p5; green <= q;  blue <= v;  end
        SEC_BM:  begin red <= t;  green <= p5; blue <= v;  end
        default: begin red <= v;  green <= p5; blue <= q;  end
      endcase
    end
  end

endmodule

### hw/rtl/hsv_to_rgb_converter.sv
// Top level of the HSV to RGB converter: six-stage pipeline plus APB registers.
//
//   channel  | direction | handshake            | payload
//   hue      | in        | hue_valid/hue_stall  | hue (10-bit signed)
//   rgb      | out       | rgb_valid/rgb_stall  | red, green, blue (8-bit)
//   config   | in        | APB psel/penable     | saturation, value_level
//
// One word per clock while rgb is not stalled; each word passes through every stage register.
// The depth is set by the two hue stages, the two multiply stages and their divide-by-255 stages.
// rst clears the valid bits and loads saturation 255, value level 220.
// A stall on rgb holds the last stage; upstream stages keep filling any bubbles.
module hsv_to_rgb_converter (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              hue_valid,
  output logic              hue_stall,
  input  logic signed [9:0] hue,
  output logic              rgb_valid,
  input  logic              rgb_stall,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);
  import hsvc_pkg::*;

  config_t               cfg;
  logic [NUM_STAGES-1:0] load;
  logic [2:0]            sector;
  logic [7:0]            frac;

  hsvc_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hsvc_flow u_flow (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hue_valid),
    .in_stall  (hue_stall),
    .out_valid (rgb_valid),
    .out_stall (rgb_stall),
    .load      (load)
  );

  hsvc_sector u_sector (
    .clk    (clk),
    .load   (load),
    .hue    (hue),
    .sector (sector),
    .frac   (frac)
  );

  hsvc_shade u_shade (
    .clk    (clk),
    .load   (load),
    .cfg    (cfg),
    .sector (sector),
    .frac   (frac),
    .red    (red),
    .green  (green),
    .blue   (blue)
  );

endmodule

### tb/tb.sv
// Self-checking testbench for the HSV to RGB converter pipeline.
`timescale 1ns / 1ps

module tb;
  import hsvc_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 200;
  localparam int NUM_PHASES = 10;
  localparam int HOLD_PHASE = 4;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam logic [2:0] ADDR_SATURATION = {REG_SATURATION, 2'b00};
  localparam logic [2:0] ADDR_VALUE = {REG_VALUE, 2'b00};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic hue_valid = 1'b0;
  logic hue_stall;
  logic signed [9:0] hue = '0;
  logic rgb_valid;
  logic rgb_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  logic signed [9:0] hue_pending[$];
  rgb_t rgb_expected[$];
  logic [7:0] cur_sat = SATURATION_RESET;
  logic [7:0] cur_val = VALUE_RESET;
  int queued_count = 0;
  int accepted_count = 0;
  int fail_count = 0;
  int cycle_count = 0;
  bit in_taken = 1'b0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int src_idle = 0;
  int sink_burst = 0;
  int hold_left = 0;

  hsv_to_rgb_converter u_dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .hue_valid(hue_valid),
    .hue_stall(hue_stall),
    .hue(hue),
    .rgb_valid(rgb_valid),
    .rgb_stall(rgb_stall),
    .red(red),
    .green(green),
    .blue(blue)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic rgb_t predict_rgb(logic signed [9:0] h_in, logic [7:0] s8, logic [7:0] v8);
    int h, sector, frac, s, v, p, q, t;
    logic [2:0] sec;
    rgb_t c;
    h = (int'(h_in) + 720) % 360;
    sector = h / 60;
    frac = (h - sector * 60) * 255 / 60;
    s = s8;
    v = v8;
    p = v * (255 - s) / 255;
    q = v * (255 - s * frac / 255) / 255;
    t = v * (255 - s * (255 - frac) / 255) / 255;
    sec = 3'(sector);
    case (sec)
      SEC_RY: c = '{8'(v), 8'(t), 8'(p)};
      SEC_YG: c = '{8'(q), 8'(v), 8'(p)};
      SEC_GC: c = '{8'(p), 8'(v), 8'(t)};
      SEC_CB: c = '{8'(p), 8'(q), 8'(v)};
      SEC_BM: c = '{8'(t), 8'(p), 8'(v)};
      default: c = '{8'(v), 8'(p), 8'(q)};
    endcase
    return c;
  endfunction

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                            input logic [7:0] readback);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr && prdata[7:0] !== readback) begin
      $error("prdata mismatch at 0x%0h: expected %0d, actual %0d", addr, readback, prdata[7:0]);
      fail_count++;
    end
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // upper data bits are junk on purpose; only the low byte lands
  task automatic set_levels(input logic [7:0] s8, input logic [7:0] v8);
    apb_access(1'b1, ADDR_SATURATION, ($urandom() & 32'hFFFF_FF00) | s8, 8'd0);
    apb_access(1'b1, ADDR_VALUE, ($urandom() & 32'hFFFF_FF00) | v8, 8'd0);
    cur_sat = s8;
    cur_val = v8;
    apb_access(1'b0, ADDR_SATURATION, 32'd0, s8);
    apb_access(1'b0, ADDR_VALUE, 32'd0, v8);
  endtask

  task automatic queue_hue(input logic signed [9:0] h);
    hue_pending.push_back(h);
    queued_count++;
  endtask

  task automatic drain_pipe();
    while (accepted_count != queued_count || rgb_expected.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // sender: one word per cycle while hue is not stalled, random bursts of idle
  always @(negedge clk) begin
    logic nv;
    logic signed [9:0] nh;
    nv = hue_valid;
    nh = hue;
    if (rst) begin
      nv = 1'b0;
    end else if (!hue_valid || in_taken) begin
      nv = 1'b0;
      if (src_idle > 0) begin
        src_idle--;
      end else if (hue_pending.size() != 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          src_idle = $urandom_range(1, 17) - 1;
        end else begin
          nh = hue_pending.pop_front();
          nv = 1'b1;
        end
      end
    end
    hue_valid <= nv;
    hue <= nh;
  end

  // receiver stall: random bursts plus one long hold-off
  always @(negedge clk) begin
    logic ns;
    if (rst) begin
      ns = 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      ns = 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      ns = 1'b1;
    end else if (sink_burst > 0) begin
      sink_burst--;
      ns = 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      sink_burst = $urandom_range(1, 17) - 1;
      ns = 1'b1;
    end else begin
      ns = 1'b0;
    end
    rgb_stall <= ns;
  end

  always @(posedge clk) begin
    rgb_t exp_c;
    in_taken = 1'b0;
    if (!rst) begin
      in_taken = hue_valid && !hue_stall;
      if (rgb_valid && !rgb_stall) begin
        if (rgb_expected.size() == 0) begin
          $error("rgb word with none expected: %0d %0d %0d", red, green, blue);
          fail_count++;
        end else begin
          exp_c = rgb_expected.pop_front();
          if (red !== exp_c.red) begin
            $error("red mismatch: expected %0d, actual %0d", exp_c.red, red);
            fail_count++;
          end
          if (green !== exp_c.green) begin
            $error("green mismatch: expected %0d, actual %0d", exp_c.green, green);
            fail_count++;
          end
          if (blue !== exp_c.blue) begin
            $error("blue mismatch: expected %0d, actual %0d", exp_c.blue, blue);
            fail_count++;
          end
        end
      end
      if (in_taken) begin
        rgb_expected.push_back(predict_rgb(hue, cur_sat, cur_val));
        accepted_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("hsv_to_rgb_converter verification failed");
      $finish;
    end
  end

  initial begin
    logic [7:0] sat_set[NUM_PHASES];
    logic [7:0] val_set[NUM_PHASES];
    int corner[$];
    int ph;
    int k;
    sat_set = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd0, 8'd0};
    val_set = '{8'd220, 8'd255, 8'd255, 8'd0, 8'd0, 8'd254, 8'd200, 8'd0, 8'd0, 8'd0};
    for (k = 7; k < NUM_PHASES; k++) begin
      sat_set[k] = 8'($urandom_range(0, 255));
      val_set[k] = 8'($urandom_range(0, 255));
    end
    // range ends, wrap points and every sector edge
    corner = '{-512, 511, -1, 0, 1, 359, 360, -360, 59, 60, 119, 120, 179, 180,
               239, 240, 299, 300, -60, -300, -301, 30, 450};
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    // first phase runs on reset register values
    foreach (corner[i]) queue_hue(10'(corner[i]));
    drain_pipe();

    for (ph = 1; ph < NUM_PHASES; ph++) begin
      set_levels(sat_set[ph], val_set[ph]);
      if (ph == HOLD_PHASE) hold_req = 1'b1;
      if (ph == NUM_PHASES - 1) quiet = 1'b1;
      for (k = 0; k < PHASE_WORDS; k++) begin
        if ($urandom_range(0, 3) == 0)
          queue_hue(10'(corner[$urandom_range(0, corner.size() - 1)]));
        else
          queue_hue(10'($urandom_range(0, 1023)));
      end
      drain_pipe();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("hsv_to_rgb_converter verification clean");
    end else begin
      $display("hsv_to_rgb_converter verification failed");
    end
    $finish;
  end

endmodule

### hsv_to_rgb_converter.f
hw/rtl/hsvc_pkg.sv
hw/rtl/hsvc_regs.sv
hw/rtl/hsvc_flow.sv
hw/rtl/hsvc_sector.sv
hw/rtl/hsvc_shade.sv
hw/rtl/hsv_to_rgb_converter.sv
tb/tb.sv
